// File: rtl/bfgm_pkg.sv
// Shared types and constants for the bitmap font glyph metrics unit.
package bfgm_pkg;

  localparam int GRID_CELLS        = 16;
  localparam int CELL_COUNT        = GRID_CELLS * GRID_CELLS;
  localparam int MAX_CELL_SIZE_DEF = 64;
  localparam int COORD_BITS_DEF    = 16;
  localparam int CELL_SIZE_RESET   = 8;

  localparam logic [7:0] CHAR_A       = 8'h41;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_CHAR  = 1'b1;

  localparam logic REG_CELL_WIDTH  = 1'b0;
  localparam logic REG_CELL_HEIGHT = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [31:0]        pixel_value;
    logic [7:0]         char_code;
    logic               string_start;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
  } bfgm_req_t;

  typedef struct packed {
    logic               draw;
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
    logic [9:0]         src_x;
    logic [9:0]         src_y;
    logic [6:0]         src_w;
    logic [6:0]         src_h;
  } bfgm_res_t;

endpackage

// File: rtl/bfgm_ram.sv
// Generic simple dual-port RAM with registered read.
module bfgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/bitmap_font_glyph_metrics_unit.sv
// Bitmap font glyph metrics: per-cell bounds from a glyph sheet, then text layout.
// Throughput: one request per cycle; busy never rises.
// A character is registered into the second stage, then its result into the output register that drives out_valid.
// Pixels give no result; each cell entry is read-modify-written in the RAM with forwarding.
// Reset clears all cell found bits at once (no clearing pass); registers return to 8.
// The receiver cannot stall; each result is shown for exactly one cycle.
module bitmap_font_glyph_metrics_unit #(
  parameter int MAX_CELL_SIZE = bfgm_pkg::MAX_CELL_SIZE_DEF,
  parameter int COORD_BITS    = bfgm_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bfgm_pkg::bfgm_req_t in_req,
  output logic                out_valid,
  output bfgm_pkg::bfgm_res_t out_res,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  import bfgm_pkg::*;

  localparam int CS_W   = $clog2(MAX_CELL_SIZE + 1);
  localparam int LW     = $clog2(MAX_CELL_SIZE);
  localparam int BW     = 2 * LW;
  localparam int AW     = $clog2(CELL_COUNT);
  localparam int GW     = $clog2(GRID_CELLS);
  localparam int PW     = CS_W + GW + 1;

  function automatic logic [CS_W-1:0] clamp_cell(input logic [6:0] v);
    logic [31:0] x;
    x = 32'(v);
    if (x == 32'd0) x = 32'd1;
    if (x > 32'(MAX_CELL_SIZE)) x = 32'(MAX_CELL_SIZE);
    return x[CS_W-1:0];
  endfunction

  // configuration and sheet state
  logic [CS_W-1:0]       cw_r, ch_r, top_r, abot_r;
  logic [31:0]           bg_r;
  logic                  started_r, ready_r;
  logic [LW-1:0]         lx_r, ly_r;
  logic [GW-1:0]         cx_r, cy_r;
  logic [CELL_COUNT-1:0] found_r;

  // layout state
  logic [COORD_BITS-1:0] cursor_x_r, cursor_y_r, line_x_r;
  logic [COORD_BITS-1:0] cursor_x_nxt, cursor_y_nxt, line_x_nxt;

  // second stage
  logic                  s1_pix_r, s1_char_r;
  logic [AW-1:0]         s1_addr_r;
  logic [LW-1:0]         s1_lx_r;
  logic                  s1_ss_r;
  logic signed [15:0]    s1_ox_r, s1_oy_r;

  // write forwarding
  logic                  fwd_vld_r;
  logic [AW-1:0]         fwd_addr_r;
  logic [BW-1:0]         fwd_data_r;

  logic                  out_valid_r;
  bfgm_res_t             out_res_r, res_nxt;

  logic                  acc, pix_acc, char_acc, first, nonbg;
  logic                  lx_end, ly_end, cx_end, cy_end, last_pix;
  logic                  cfg_we;
  logic [AW-1:0]         pix_addr, rd_addr;
  logic                  ram_we;
  logic [BW-1:0]         ram_wdata, ram_rdata, base;
  logic [LW-1:0]         b_left, b_right;
  logic                  s1_found;
  logic [7:0]            s1_ch;
  logic                  is_space, is_newline, draw;
  logic [31:0]           sw32, sx32, sy32, sh32;
  logic [PW-1:0]         col_w, row_h;
  logic [31:0]           ld_x, ld_y;
  logic [COORD_BITS-1:0] cur_x, cur_y, cur_line;
  logic [31:0]           dx32, dy32;

  assign busy     = 1'b0;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_CELL_HEIGHT) ? 32'(ch_r) : 32'(cw_r);

  assign acc      = start & ~busy;
  assign pix_acc  = acc & (in_req.req_type == REQ_PIXEL) & ~ready_r;
  assign char_acc = acc & (in_req.req_type == REQ_CHAR);
  assign first    = ~started_r;
  assign nonbg    = in_req.pixel_value != bg_r;
  assign cfg_we   = psel & penable & pwrite & pready & ~started_r;

  assign lx_end   = CS_W'(lx_r) == (cw_r - CS_W'(1));
  assign ly_end   = CS_W'(ly_r) == (ch_r - CS_W'(1));
  assign cx_end   = cx_r == GW'(GRID_CELLS - 1);
  assign cy_end   = cy_r == GW'(GRID_CELLS - 1);
  assign last_pix = lx_end & cx_end & ly_end & cy_end;

  assign pix_addr = {cy_r, cx_r};
  assign rd_addr  = (in_req.req_type == REQ_PIXEL) ? pix_addr : in_req.char_code;

  bfgm_ram #(
    .WIDTH (BW),
    .DEPTH (CELL_COUNT)
  ) u_bounds (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (ram_wdata),
    .re    (pix_acc | char_acc),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // cell bounds merge
  always_comb begin
    base     = (fwd_vld_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : ram_rdata;
    b_left   = base[LW-1:0];
    b_right  = base[BW-1:LW];
    s1_found = found_r[s1_addr_r];
    ram_we   = s1_pix_r;
    if (s1_found) begin
      ram_wdata = {((s1_lx_r > b_right) ? s1_lx_r : b_right),
                   ((s1_lx_r < b_left) ? s1_lx_r : b_left)};
    end else begin
      ram_wdata = {s1_lx_r, s1_lx_r};
    end
  end

  // character layout
  always_comb begin
    s1_ch      = s1_addr_r;
    is_space   = s1_ch == CHAR_SPACE;
    is_newline = s1_ch == CHAR_NEWLINE;
    draw       = ready_r & ~is_space & ~is_newline;

    ld_x     = 32'(s1_ox_r);
    ld_y     = 32'(s1_oy_r);
    cur_x    = s1_ss_r ? ld_x[COORD_BITS-1:0] : cursor_x_r;
    cur_y    = s1_ss_r ? ld_y[COORD_BITS-1:0] : cursor_y_r;
    cur_line = s1_ss_r ? ld_x[COORD_BITS-1:0] : line_x_r;

    col_w = PW'(s1_ch[GW-1:0]) * PW'(cw_r);
    row_h = PW'(s1_ch[7:GW]) * PW'(ch_r);
    if (s1_found) begin
      sw32 = 32'(b_right) - 32'(b_left) + 32'd1;
      sx32 = 32'(col_w) + 32'(b_left);
    end else begin
      sw32 = 32'(cw_r);
      sx32 = 32'(col_w);
    end
    sy32 = 32'(row_h) + 32'(top_r);
    sh32 = 32'(ch_r) - 32'(top_r);
    dx32 = 32'(cur_x);
    dy32 = 32'(cur_y);

    res_nxt = '0;
    if (draw) begin
      res_nxt.draw   = 1'b1;
      res_nxt.dest_x = dx32[15:0];
      res_nxt.dest_y = dy32[15:0];
      res_nxt.src_x  = sx32[9:0];
      res_nxt.src_y  = sy32[9:0];
      res_nxt.src_w  = sw32[6:0];
      res_nxt.src_h  = sh32[6:0];
    end

    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    line_x_nxt   = line_x_r;
    if (s1_char_r && ready_r) begin
      line_x_nxt   = cur_line;
      cursor_y_nxt = cur_y;
      if (is_space) begin
        cursor_x_nxt = COORD_BITS'(32'(cur_x) + 32'(cw_r >> 1));
      end else if (is_newline) begin
        cursor_y_nxt = COORD_BITS'(32'(cur_y) + 32'(abot_r) - 32'(top_r));
        cursor_x_nxt = cur_line;
      end else begin
        cursor_x_nxt = COORD_BITS'(32'(cur_x) + sw32 + 32'd1);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r        <= CS_W'(CELL_SIZE_RESET);
      ch_r        <= CS_W'(CELL_SIZE_RESET);
      top_r       <= CS_W'(CELL_SIZE_RESET);
      abot_r      <= CS_W'(CELL_SIZE_RESET);
      started_r   <= 1'b0;
      ready_r     <= 1'b0;
      lx_r        <= '0;
      ly_r        <= '0;
      cx_r        <= '0;
      cy_r        <= '0;
      found_r     <= '0;
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      line_x_r    <= '0;
      s1_pix_r    <= 1'b0;
      s1_char_r   <= 1'b0;
      fwd_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (paddr[2] == REG_CELL_HEIGHT) begin
          ch_r   <= clamp_cell(pwdata[6:0]);
          top_r  <= clamp_cell(pwdata[6:0]);
          abot_r <= clamp_cell(pwdata[6:0]);
        end else begin
          cw_r <= clamp_cell(pwdata[6:0]);
        end
      end

      if (pix_acc) begin
        started_r <= 1'b1;
        if (last_pix) begin
          ready_r <= 1'b1;
        end
        if (first) begin
          top_r  <= ch_r;
          abot_r <= ch_r;
        end else if (nonbg) begin
          if (CS_W'(ly_r) < top_r) begin
            top_r <= CS_W'(ly_r);
          end
          if ((pix_addr == CHAR_A) && ((abot_r == ch_r) || (CS_W'(ly_r) > abot_r))) begin
            abot_r <= CS_W'(ly_r);
          end
        end
        if (lx_end) begin
          lx_r <= '0;
          if (cx_end) begin
            cx_r <= '0;
            if (ly_end) begin
              ly_r <= '0;
              cy_r <= cy_r + GW'(1);
            end else begin
              ly_r <= ly_r + LW'(1);
            end
          end else begin
            cx_r <= cx_r + GW'(1);
          end
        end else begin
          lx_r <= lx_r + LW'(1);
        end
      end

      if (ram_we) begin
        found_r[s1_addr_r] <= 1'b1;
      end

      cursor_x_r  <= cursor_x_nxt;
      cursor_y_r  <= cursor_y_nxt;
      line_x_r    <= line_x_nxt;
      s1_pix_r    <= pix_acc & ~first & nonbg;
      s1_char_r   <= char_acc;
      fwd_vld_r   <= ram_we;
      out_valid_r <= s1_char_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pix_acc && first) begin
      bg_r <= in_req.pixel_value;
    end
    if (pix_acc | char_acc) begin
      s1_addr_r <= rd_addr;
      s1_lx_r   <= lx_r;
      s1_ss_r   <= in_req.string_start;
      s1_ox_r   <= in_req.origin_x;
      s1_oy_r   <= in_req.origin_y;
    end
    fwd_addr_r <= s1_addr_r;
    fwd_data_r <= ram_wdata;
    out_res_r  <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
